/* rtl/core/assert_macros.svh */
// Assertion helpers, clocked on clk with rst_n as the disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BRBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brbs assertion failed");

// Delayed implication, with the delay given by dly.
`define BRBS_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("brbs assertion failed");

`endif

/* rtl/core/brbs_pkg.sv */
package brbs_pkg;

    localparam int KIN_STAGES  = 9;
    localparam int NORM_STAGES = 5;
    localparam int ROOT_STEPS  = 32;
    localparam int DIV_STEPS   = 32;
    localparam int LATENCY     = KIN_STAGES + NORM_STAGES + ROOT_STEPS + DIV_STEPS + 1;

    localparam int CFG_W = 63;

    // register indexes
    localparam logic [2:0] REG_ROT_DRIFT   = 3'd0;
    localparam logic [2:0] REG_ROT_NOISE   = 3'd1;
    localparam logic [2:0] REG_TRANS_DRIFT = 3'd2;
    localparam logic [2:0] REG_TRANS_NOISE = 3'd3;
    localparam logic [2:0] REG_TIME_STEP   = 3'd4;
    localparam logic [2:0] REG_DIM_MODE    = 3'd5;
    localparam logic [2:0] REG_NOISE_MODE  = 3'd6;

    localparam logic [1:0] DIM_3D     = 2'd0;
    localparam logic [1:0] DIM_2D     = 2'd1;
    localparam logic [1:0] DIM_PLANAR = 2'd2;

    localparam logic [1:0] NOISE_OFF     = 2'd0;
    localparam logic [1:0] NOISE_UNIFORM = 2'd1;
    localparam logic [1:0] NOISE_GAUSS   = 2'd2;

    localparam logic signed [16:0] HALF_Q12 = 17'sd2048;
    localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
    localparam logic signed [31:0] S32_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

    typedef logic signed [31:0] s32_t;
    typedef logic signed [33:0] s34_t;
    typedef logic signed [35:0] s36_t;

    typedef struct packed {
        s32_t        quat_w;
        s32_t        quat_x;
        s32_t        quat_y;
        s32_t        quat_z;
        s32_t        torque_x;
        s32_t        torque_y;
        s32_t        torque_z;
        s32_t        force_x;
        s32_t        force_y;
        s32_t        force_z;
        logic [47:0] rot_noise;
        logic [47:0] trans_noise;
    } item_t;

    typedef struct packed {
        s32_t new_quat_w;
        s32_t new_quat_x;
        s32_t new_quat_y;
        s32_t new_quat_z;
        s32_t vel_x;
        s32_t vel_y;
        s32_t vel_z;
        s32_t disp_x;
        s32_t disp_y;
        s32_t disp_z;
        logic saturated;
    } result_t;

    typedef struct packed {
        logic [62:0] rot_drift;
        logic [62:0] rot_noise;
        logic [62:0] trans_drift;
        logic [62:0] trans_noise;
        logic [31:0] time_step;
        logic [1:0]  dim_mode;
        logic [1:0]  noise_mode;
    } cfg_t;

    typedef struct packed {
        s32_t [3:0] q;
        s32_t [3:0] rate;
        s32_t [2:0] vel;
        logic       sat;
    } kin_out_t;

    typedef struct packed {
        logic [3:0][30:0] mag;
        logic [3:0]       neg;
        s32_t [2:0]       vel;
        s32_t [2:0]       disp;
        logic             sat;
    } root_side_t;

    // Q2.30 product, floor shift
    function automatic s34_t mul_q30(input s32_t a, input s32_t b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    function automatic logic ovf32(input logic signed [47:0] v);
        return (v > 48'sd2147483647) || (v < -48'sd2147483648);
    endfunction

    function automatic s32_t clamp32(input logic signed [47:0] v);
        s32_t r;
        if (v > 48'sd2147483647)
            r = S32_MAX;
        else if (v < -48'sd2147483648)
            r = S32_MIN;
        else
            r = $signed(v[31:0]);
        return r;
    endfunction

endpackage

/* rtl/core/brbs_kin.sv */
module brbs_kin (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  brbs_pkg::item_t    in_item,
    input  brbs_pkg::cfg_t     cfg,
    output logic               out_valid,
    output brbs_pkg::kin_out_t out_data
);
    import brbs_pkg::*;

    localparam int PQ_WW = 0, PQ_XX = 1, PQ_YY = 2, PQ_ZZ = 3, PQ_XY = 4;
    localparam int PQ_XZ = 5, PQ_YZ = 6, PQ_WX = 7, PQ_WY = 8, PQ_WZ = 9;

    logic [KIN_STAGES-1:0] vld_reg;

    item_t              item_reg [1:8];
    s34_t               pq_reg   [0:9];
    s34_t               pq_next  [0:9];
    s32_t               rm_reg   [3:7][0:2][0:2];
    s32_t               rm_next  [0:2][0:2];
    logic signed [47:0] rraw     [0:2][0:2];
    logic               sat_reg  [3:8];
    logic               sat3_next;
    logic               sat7_next;
    s34_t               bp_reg   [0:1][0:2][0:2];
    s34_t               bp_next  [0:1][0:2][0:2];
    s36_t               bs_reg   [0:1][0:2];
    s36_t               bs_next  [0:1][0:2];
    logic signed [41:0] drv_reg  [0:1][0:2];
    logic signed [41:0] drv_next [0:1][0:2];
    logic signed [26:0] nse_reg  [0:1][0:2];
    logic signed [26:0] nse_next [0:1][0:2];
    s32_t               ax_reg   [0:1][0:2];
    s32_t               ax_next  [0:1][0:2];
    s34_t               qw_reg   [0:3][0:2];
    s34_t               qw_next  [0:3][0:2];
    s34_t               lp_reg   [0:2][0:2];
    s34_t               lp_next  [0:2][0:2];
    kin_out_t           out_reg;
    kin_out_t           out_next;

    s32_t               qa [0:3];
    s32_t               qg [0:3];
    s32_t               vin [0:1][0:2];
    logic [20:0]        dc;
    logic [20:0]        nc;
    logic signed [15:0] smp;
    logic signed [16:0] nval;
    logic signed [57:0] pd;
    logic signed [38:0] pn;
    logic signed [47:0] acc;
    logic               zero;
    logic               planar_rot;
    logic               flat;
    logic signed [47:0] rs [0:3];
    logic signed [47:0] vs [0:2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[KIN_STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        // rank 2: quaternion products
        qa[0] = item_reg[1].quat_w;
        qa[1] = item_reg[1].quat_x;
        qa[2] = item_reg[1].quat_y;
        qa[3] = item_reg[1].quat_z;
        pq_next[PQ_WW] = mul_q30(qa[0], qa[0]);
        pq_next[PQ_XX] = mul_q30(qa[1], qa[1]);
        pq_next[PQ_YY] = mul_q30(qa[2], qa[2]);
        pq_next[PQ_ZZ] = mul_q30(qa[3], qa[3]);
        pq_next[PQ_XY] = mul_q30(qa[1], qa[2]);
        pq_next[PQ_XZ] = mul_q30(qa[1], qa[3]);
        pq_next[PQ_YZ] = mul_q30(qa[2], qa[3]);
        pq_next[PQ_WX] = mul_q30(qa[0], qa[1]);
        pq_next[PQ_WY] = mul_q30(qa[0], qa[2]);
        pq_next[PQ_WZ] = mul_q30(qa[0], qa[3]);

        // rank 3: rotation matrix
        rraw[0][0] = 48'(pq_reg[PQ_WW]) + 48'(pq_reg[PQ_XX])
                   - 48'(pq_reg[PQ_YY]) - 48'(pq_reg[PQ_ZZ]);
        rraw[0][1] = (48'(pq_reg[PQ_XY]) - 48'(pq_reg[PQ_WZ])) <<< 1;
        rraw[0][2] = (48'(pq_reg[PQ_XZ]) + 48'(pq_reg[PQ_WY])) <<< 1;
        rraw[1][0] = (48'(pq_reg[PQ_XY]) + 48'(pq_reg[PQ_WZ])) <<< 1;
        rraw[1][1] = 48'(pq_reg[PQ_WW]) - 48'(pq_reg[PQ_XX])
                   + 48'(pq_reg[PQ_YY]) - 48'(pq_reg[PQ_ZZ]);
        rraw[1][2] = (48'(pq_reg[PQ_YZ]) - 48'(pq_reg[PQ_WX])) <<< 1;
        rraw[2][0] = (48'(pq_reg[PQ_XZ]) - 48'(pq_reg[PQ_WY])) <<< 1;
        rraw[2][1] = (48'(pq_reg[PQ_YZ]) + 48'(pq_reg[PQ_WX])) <<< 1;
        rraw[2][2] = 48'(pq_reg[PQ_WW]) - 48'(pq_reg[PQ_XX])
                   - 48'(pq_reg[PQ_YY]) + 48'(pq_reg[PQ_ZZ]);
        sat3_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rm_next[r][c] = clamp32(rraw[r][c]);
                sat3_next     = sat3_next | ovf32(rraw[r][c]);
            end
        end

        // rank 4: transposed rotation products (0 torque, 1 force)
        vin[0][0] = item_reg[3].torque_x;
        vin[0][1] = item_reg[3].torque_y;
        vin[0][2] = item_reg[3].torque_z;
        vin[1][0] = item_reg[3].force_x;
        vin[1][1] = item_reg[3].force_y;
        vin[1][2] = item_reg[3].force_z;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    bp_next[s][i][r] = mul_q30(rm_reg[3][r][i], vin[s][r]);
                end
            end
        end

        // rank 5: body frame sums
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bs_next[s][i] = 36'(bp_reg[s][i][0]) + 36'(bp_reg[s][i][1])
                              + 36'(bp_reg[s][i][2]);
            end
        end

        // rank 6: drift and noise terms
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dc  = (s == 0) ? cfg.rot_drift[21*i +: 21] : cfg.trans_drift[21*i +: 21];
                nc  = (s == 0) ? cfg.rot_noise[21*i +: 21] : cfg.trans_noise[21*i +: 21];
                smp = (s == 0) ? $signed(item_reg[5].rot_noise[16*i +: 16])
                               : $signed(item_reg[5].trans_noise[16*i +: 16]);
                unique case (cfg.noise_mode)
                    NOISE_UNIFORM: nval = 17'(smp) - HALF_Q12;
                    NOISE_GAUSS:   nval = 17'(smp);
                    default:       nval = '0;
                endcase
                pd = $signed({1'b0, dc}) * bs_reg[s][i];
                pn = $signed({1'b0, nc}) * nval;
                drv_next[s][i] = pd[57:16];
                nse_next[s][i] = pn[38:12];
            end
        end

        // rank 7: body rates, with the modes forcing axes to zero
        planar_rot = (cfg.dim_mode == DIM_2D) || (cfg.dim_mode == DIM_PLANAR);
        flat       = (cfg.dim_mode == DIM_2D);
        sat7_next  = sat_reg[6];
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc  = 48'(drv_reg[s][i]) + 48'(nse_reg[s][i]);
                zero = ((s == 0) && (i < 2) && planar_rot) || ((s == 1) && (i == 2) && flat);
                ax_next[s][i] = zero ? '0 : clamp32(acc);
                sat7_next     = sat7_next | (!zero && ovf32(acc));
            end
        end

        // rank 8: quaternion rate and lab frame products
        qg[0] = item_reg[7].quat_w;
        qg[1] = item_reg[7].quat_x;
        qg[2] = item_reg[7].quat_y;
        qg[3] = item_reg[7].quat_z;
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                qw_next[a][b] = mul_q30(qg[a], ax_reg[0][b]);
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lp_next[r][c] = mul_q30(rm_reg[7][r][c], ax_reg[1][c]);
            end
        end

        // rank 9: sums and clamps
        rs[0] = -48'(qw_reg[1][0]) - 48'(qw_reg[2][1]) - 48'(qw_reg[3][2]);
        rs[1] =  48'(qw_reg[0][0]) + 48'(qw_reg[2][2]) - 48'(qw_reg[3][1]);
        rs[2] =  48'(qw_reg[0][1]) + 48'(qw_reg[3][0]) - 48'(qw_reg[1][2]);
        rs[3] =  48'(qw_reg[0][2]) + 48'(qw_reg[1][1]) - 48'(qw_reg[2][0]);
        for (int r = 0; r < 3; r++)
        begin
            vs[r] = 48'(lp_reg[r][0]) + 48'(lp_reg[r][1]) + 48'(lp_reg[r][2]);
        end
        out_next.q[0] = item_reg[8].quat_w;
        out_next.q[1] = item_reg[8].quat_x;
        out_next.q[2] = item_reg[8].quat_y;
        out_next.q[3] = item_reg[8].quat_z;
        out_next.sat  = sat_reg[8];
        for (int a = 0; a < 4; a++)
        begin
            out_next.rate[a] = clamp32(rs[a]);
            out_next.sat     = out_next.sat | ovf32(rs[a]);
        end
        for (int r = 0; r < 3; r++)
        begin
            out_next.vel[r] = clamp32(vs[r]);
            out_next.sat    = out_next.sat | ovf32(vs[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[1] <= in_item;
        for (int k = 2; k <= 8; k++)
        begin
            item_reg[k] <= item_reg[k-1];
        end
        pq_reg     <= pq_next;
        rm_reg[3]  <= rm_next;
        for (int k = 4; k <= 7; k++)
        begin
            rm_reg[k] <= rm_reg[k-1];
        end
        sat_reg[3] <= sat3_next;
        sat_reg[4] <= sat_reg[3];
        sat_reg[5] <= sat_reg[4];
        sat_reg[6] <= sat_reg[5];
        sat_reg[7] <= sat7_next;
        sat_reg[8] <= sat_reg[7];
        bp_reg     <= bp_next;
        bs_reg     <= bs_next;
        drv_reg    <= drv_next;
        nse_reg    <= nse_next;
        ax_reg     <= ax_next;
        qw_reg     <= qw_next;
        lp_reg     <= lp_next;
        out_reg    <= out_next;
    end

    assign out_valid = vld_reg[KIN_STAGES-1];
    assign out_data  = out_reg;

endmodule

/* rtl/core/brbs_norm.sv */
module brbs_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  brbs_pkg::kin_out_t   in_data,
    input  logic [31:0]          time_step,
    output logic                 out_valid,
    output logic [63:0]          out_n2,
    output brbs_pkg::root_side_t out_side
);
    import brbs_pkg::*;

    logic [NORM_STAGES-1:0] vld_reg;

    kin_out_t           kin_reg;
    logic signed [45:0] dq_reg   [0:3];
    logic signed [45:0] dq_next  [0:3];
    s32_t               disp_next [0:2];
    s32_t               disp_reg [0:2];
    logic [46:0]        mag_reg  [11:12][0:3];
    logic [46:0]        mag_next [0:3];
    root_side_t         side_reg [11:14];
    root_side_t         side11_next;
    root_side_t         side13_next;
    logic [4:0]         shift_reg;
    logic [4:0]         shift_next;
    logic [61:0]        sq_reg   [0:3];
    logic [61:0]        sq_next  [0:3];
    logic [63:0]        n2_reg;

    logic signed [32:0] dts;
    logic signed [64:0] pr;
    logic signed [64:0] pv;
    logic signed [46:0] qn;
    logic [46:0]        any_bits;
    logic [5:0]         msb;
    logic [30:0]        sm;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NORM_STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        // rank 10: products with the time step
        dts = $signed({1'b0, time_step});
        for (int i = 0; i < 4; i++)
        begin
            pr         = dts * in_data.rate[i];
            dq_next[i] = pr[64:19];
        end
        for (int i = 0; i < 3; i++)
        begin
            pv           = dts * in_data.vel[i];
            disp_next[i] = pv[63:32];
        end

        // rank 11: stepped quaternion, sign and magnitude
        side11_next     = '0;
        side11_next.sat = kin_reg.sat;
        for (int i = 0; i < 3; i++)
        begin
            side11_next.vel[i]  = kin_reg.vel[i];
            side11_next.disp[i] = disp_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            qn                 = 47'(kin_reg.q[i]) + 47'(dq_reg[i]);
            side11_next.neg[i] = qn[46];
            mag_next[i]        = qn[46] ? 47'(-qn) : 47'(qn);
        end

        // rank 12: common shift so every magnitude drops below 2^31
        any_bits = mag_reg[11][0] | mag_reg[11][1] | mag_reg[11][2] | mag_reg[11][3];
        msb = '0;
        for (int j = 0; j < 47; j++)
        begin
            if (any_bits[j])
            begin
                msb = 6'(j);
            end
        end
        shift_next = (msb > 6'd30) ? 5'(msb - 6'd30) : 5'd0;

        // rank 13: shifted magnitudes and squares
        side13_next = side_reg[12];
        for (int i = 0; i < 4; i++)
        begin
            sm                 = 31'(mag_reg[12][i] >> shift_reg);
            side13_next.mag[i] = sm;
            sq_next[i]         = sm * sm;
        end
    end

    always_ff @(posedge clk)
    begin
        kin_reg      <= in_data;
        dq_reg       <= dq_next;
        disp_reg     <= disp_next;
        mag_reg[11]  <= mag_next;
        side_reg[11] <= side11_next;
        mag_reg[12]  <= mag_reg[11];
        side_reg[12] <= side_reg[11];
        shift_reg    <= shift_next;
        sq_reg       <= sq_next;
        side_reg[13] <= side13_next;
        n2_reg       <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]) + 64'(sq_reg[3]);
        side_reg[14] <= side_reg[13];
    end

    assign out_valid = vld_reg[NORM_STAGES-1];
    assign out_n2    = n2_reg;
    assign out_side  = side_reg[14];

endmodule

/* rtl/core/brbs_isqrt.sv */
module brbs_isqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_n2,
    input  brbs_pkg::root_side_t in_side,
    output logic                 out_valid,
    output logic [31:0]          out_root,
    output brbs_pkg::root_side_t out_side
);
    import brbs_pkg::*;

    logic [ROOT_STEPS-1:0] vld_reg;
    logic [63:0]           rem_reg  [ROOT_STEPS];
    logic [63:0]           res_reg  [ROOT_STEPS];
    root_side_t            side_reg [ROOT_STEPS];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_STEPS-2:0], in_valid};
        end
    end

    // one result bit per stage, digit-by-digit square root
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (2 * (ROOT_STEPS - 1 - k));
        logic [63:0] rem_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        root_side_t  side_in;

        if (k == 0) begin : g_first
            assign rem_in  = in_n2;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in;
            if (rem_in >= trial)
            begin
                rem_reg[k] <= rem_in - trial;
                res_reg[k] <= (res_in >> 1) + BIT;
            end
            else
            begin
                rem_reg[k] <= rem_in;
                res_reg[k] <= res_in >> 1;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STEPS-1];
    assign out_root  = res_reg[ROOT_STEPS-1][31:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

/* rtl/core/brbs_div.sv */
module brbs_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          in_root,
    input  brbs_pkg::root_side_t in_side,
    output logic                 out_valid,
    output logic [3:0][31:0]     out_quo,
    output logic [3:0]           out_ovf,
    output logic                 out_zero,
    output brbs_pkg::root_side_t out_side
);
    import brbs_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    logic [3:0][63:0]     rem_reg  [DIV_STEPS];
    logic [3:0][31:0]     quo_reg  [DIV_STEPS];
    logic [3:0]           ovf_reg  [DIV_STEPS];
    logic                 zero_reg [DIV_STEPS];
    logic [31:0]          root_reg [DIV_STEPS];
    root_side_t           side_reg [DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    // restoring division of mag * 2^30 by the root, one quotient bit per stage;
    // a quotient of 2^32 or more is flagged up front and clamps later
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        logic [3:0][63:0] rem_in;
        logic [3:0][63:0] rem_out;
        logic [3:0][31:0] quo_in;
        logic [3:0][31:0] quo_out;
        logic [3:0]       ovf_in;
        logic             zero_in;
        logic [31:0]      root_in;
        root_side_t       side_in;
        logic [63:0]      dsh;

        if (k == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rem_in[l] = 64'(in_side.mag[l]) << 30;
                    ovf_in[l] = 34'(in_side.mag[l]) >= (34'(in_root) << 2);
                end
            end
            assign quo_in  = '0;
            assign zero_in = (in_root == '0);
            assign root_in = in_root;
            assign side_in = in_side;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign zero_in = zero_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign dsh = 64'(root_in) << SH;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                quo_out[l] = quo_in[l];
                if (rem_in[l] >= dsh)
                begin
                    rem_out[l]     = rem_in[l] - dsh;
                    quo_out[l][SH] = 1'b1;
                end
                else
                begin
                    rem_out[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_out;
            quo_reg[k]  <= quo_out;
            ovf_reg[k]  <= ovf_in;
            zero_reg[k] <= zero_in;
            root_reg[k] <= root_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];
    assign out_ovf   = ovf_reg[DIV_STEPS-1];
    assign out_zero  = zero_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

/* rtl/core/brownian_rigid_body_step_unit.sv */
// Channel   Ports                            Direction  Transfer
// request   start, busy, item                in         start high, busy low
// result    done, result                     out        done high for one cycle
// config    cfg_we, cfg_index, cfg_data      in         cfg_we high
//
// Fully pipelined: one request per cycle, busy is always low.
// A request passes from the accepting edge to done through 9 rotation/rate
// stages, 5 quaternion step and norm stages, 32 square-root stages,
// 32 divider stages and one output register. The square-root and divider
// chains, one result bit per stage, set the depth.
// Reset clears valid bits and configuration (all zero); no stalls exist.
`include "assert_macros.svh"

module brownian_rigid_body_step_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  brbs_pkg::item_t              item,
    output logic                         done,
    output brbs_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [brbs_pkg::CFG_W-1:0]   cfg_data
);
    import brbs_pkg::*;

    cfg_t       cfg_reg;
    logic       accept;

    logic       kin_valid;
    kin_out_t   kin_data;
    logic       norm_valid;
    logic [63:0] norm_n2;
    root_side_t norm_side;
    logic       root_valid;
    logic [31:0] root_val;
    root_side_t root_side;
    logic       div_valid;
    logic [3:0][31:0] div_quo;
    logic [3:0] div_ovf;
    logic       div_zero;
    root_side_t div_side;

    logic       done_reg;
    result_t    result_reg;
    result_t    result_next;
    s32_t       lane [0:3];
    logic       lane_sat;
    logic signed [33:0] sval;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_DRIFT:   cfg_reg.rot_drift   <= cfg_data;
                REG_ROT_NOISE:   cfg_reg.rot_noise   <= cfg_data;
                REG_TRANS_DRIFT: cfg_reg.trans_drift <= cfg_data;
                REG_TRANS_NOISE: cfg_reg.trans_noise <= cfg_data;
                REG_TIME_STEP:   cfg_reg.time_step   <= cfg_data[31:0];
                REG_DIM_MODE:    cfg_reg.dim_mode    <= cfg_data[1:0];
                REG_NOISE_MODE:  cfg_reg.noise_mode  <= cfg_data[1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    brbs_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .cfg       (cfg_reg),
        .out_valid (kin_valid),
        .out_data  (kin_data)
    );

    brbs_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kin_valid),
        .in_data   (kin_data),
        .time_step (cfg_reg.time_step),
        .out_valid (norm_valid),
        .out_n2    (norm_n2),
        .out_side  (norm_side)
    );

    brbs_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_n2     (norm_n2),
        .in_side   (norm_side),
        .out_valid (root_valid),
        .out_root  (root_val),
        .out_side  (root_side)
    );

    brbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_root   (root_val),
        .in_side   (root_side),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_ovf   (div_ovf),
        .out_zero  (div_zero),
        .out_side  (div_side)
    );

    // sign restore and clamp; a zero norm gives the identity rotation
    always_comb
    begin
        lane_sat = div_side.sat;
        for (int l = 0; l < 4; l++)
        begin
            sval = div_side.neg[l] ? -$signed({2'b00, div_quo[l]})
                                   :  $signed({2'b00, div_quo[l]});
            if (div_zero)
            begin
                lane[l] = (l == 0) ? ONE_Q30 : '0;
            end
            else if (div_ovf[l])
            begin
                lane[l]  = div_side.neg[l] ? S32_MIN : S32_MAX;
                lane_sat = 1'b1;
            end
            else
            begin
                lane[l]  = clamp32(48'(sval));
                lane_sat = lane_sat | ovf32(48'(sval));
            end
        end
        result_next.new_quat_w = lane[0];
        result_next.new_quat_x = lane[1];
        result_next.new_quat_y = lane[2];
        result_next.new_quat_z = lane[3];
        result_next.vel_x      = div_side.vel[0];
        result_next.vel_y      = div_side.vel[1];
        result_next.vel_z      = div_side.vel[2];
        result_next.disp_x     = div_side.disp[0];
        result_next.disp_y     = div_side.disp[1];
        result_next.disp_z     = div_side.disp[2];
        result_next.saturated  = lane_sat;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `BRBS_ASSERT_DLY(a_req_gives_result, accept, LATENCY, done)
    `BRBS_ASSERT_IMP(a_result_has_req, done, $past(accept, LATENCY))
    `BRBS_ASSERT_IMP(a_zero_norm_identity, done && $past(div_zero),
        result.new_quat_w == ONE_Q30)

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    import brbs_pkg::*;

    class brbs_scoreboard;
        cfg_t    regs;
        result_t pending_q[$];
        int      n_errors;
        int      n_checked;
        int      n_sat;

        function new();
            regs = '0;
            n_errors = 0;
            n_checked = 0;
            n_sat = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ROT_DRIFT:   regs.rot_drift = data;
                REG_ROT_NOISE:   regs.rot_noise = data;
                REG_TRANS_DRIFT: regs.trans_drift = data;
                REG_TRANS_NOISE: regs.trans_noise = data;
                REG_TIME_STEP:   regs.time_step = data[31:0];
                REG_DIM_MODE:    regs.dim_mode = data[1:0];
                REG_NOISE_MODE:  regs.noise_mode = data[1:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v, inout bit sat);
            if (v > 64'sd2147483647)
            begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                sat = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // drift plus noise for one body axis
        function longint axis_speed(longint drive, logic [62:0] dreg, logic [62:0] nreg,
                                    logic [47:0] samples, int ax, inout bit sat);
            longint dc;
            longint nc;
            longint smp;
            longint n;
            dc = longint'(dreg[21*ax +: 21]);
            nc = longint'(nreg[21*ax +: 21]);
            smp = longint'($signed(samples[16*ax +: 16]));
            n = 0;
            if (regs.noise_mode == NOISE_UNIFORM)
                n = smp - longint'(HALF_Q12);
            else if (regs.noise_mode == NOISE_GAUSS)
                n = smp;
            return clip32(((dc * drive) >>> 16) + ((nc * n) >>> 12), sat);
        endfunction

        function result_t predict_step(item_t it);
            longint q[4];
            longint tq[3];
            longint fc[3];
            longint rm[3][3];
            longint tb[3];
            longint fb[3];
            longint w[3];
            longint vb[3];
            longint v[3];
            longint rate[4];
            longint qn[4];
            longint nq[4];
            longint p[4][4];
            longint unsigned mag[4];
            longint unsigned n2;
            longint unsigned root;
            longint dt;
            int sh;
            bit sat;
            bit big;
            bit planar_rot;
            bit flat;
            result_t r;
            sat = 0;
            dt = longint'(regs.time_step);
            planar_rot = (regs.dim_mode == DIM_2D) || (regs.dim_mode == DIM_PLANAR);
            flat = (regs.dim_mode == DIM_2D);
            q[0] = it.quat_w;
            q[1] = it.quat_x;
            q[2] = it.quat_y;
            q[3] = it.quat_z;
            tq[0] = it.torque_x;
            tq[1] = it.torque_y;
            tq[2] = it.torque_z;
            fc[0] = it.force_x;
            fc[1] = it.force_y;
            fc[2] = it.force_z;
            for (int a = 0; a < 4; a++)
                for (int b = 0; b < 4; b++)
                    p[a][b] = (q[a] * q[b]) >>> 30;
            rm[0][0] = p[0][0] + p[1][1] - p[2][2] - p[3][3];
            rm[0][1] = 2 * (p[1][2] - p[0][3]);
            rm[0][2] = 2 * (p[1][3] + p[0][2]);
            rm[1][0] = 2 * (p[1][2] + p[0][3]);
            rm[1][1] = p[0][0] - p[1][1] + p[2][2] - p[3][3];
            rm[1][2] = 2 * (p[2][3] - p[0][1]);
            rm[2][0] = 2 * (p[1][3] - p[0][2]);
            rm[2][1] = 2 * (p[2][3] + p[0][1]);
            rm[2][2] = p[0][0] - p[1][1] - p[2][2] + p[3][3];
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    rm[a][b] = clip32(rm[a][b], sat);
            // transposed matrix takes lab vectors into the body frame
            for (int i = 0; i < 3; i++)
            begin
                tb[i] = ((rm[0][i] * tq[0]) >>> 30) + ((rm[1][i] * tq[1]) >>> 30)
                        + ((rm[2][i] * tq[2]) >>> 30);
                fb[i] = ((rm[0][i] * fc[0]) >>> 30) + ((rm[1][i] * fc[1]) >>> 30)
                        + ((rm[2][i] * fc[2]) >>> 30);
            end
            for (int i = 0; i < 3; i++)
                w[i] = (planar_rot && i < 2) ? 0 :
                    axis_speed(tb[i], regs.rot_drift, regs.rot_noise, it.rot_noise, i, sat);
            rate[0] = -((q[1] * w[0]) >>> 30) - ((q[2] * w[1]) >>> 30) - ((q[3] * w[2]) >>> 30);
            rate[1] = ((q[0] * w[0]) >>> 30) + ((q[2] * w[2]) >>> 30) - ((q[3] * w[1]) >>> 30);
            rate[2] = ((q[0] * w[1]) >>> 30) + ((q[3] * w[0]) >>> 30) - ((q[1] * w[2]) >>> 30);
            rate[3] = ((q[0] * w[2]) >>> 30) + ((q[1] * w[1]) >>> 30) - ((q[2] * w[0]) >>> 30);
            for (int i = 0; i < 4; i++)
            begin
                rate[i] = clip32(rate[i], sat);
                qn[i] = q[i] + ((dt * rate[i]) >>> 19);
                mag[i] = (qn[i] < 0) ? longint'(-qn[i]) : qn[i];
            end
            sh = 0;
            do
            begin
                big = 0;
                for (int i = 0; i < 4; i++)
                    if ((mag[i] >> sh) >= (64'd1 << 31))
                        big = 1;
                if (big)
                    sh++;
            end while (big);
            n2 = 0;
            for (int i = 0; i < 4; i++)
            begin
                mag[i] >>= sh;
                n2 += mag[i] * mag[i];
            end
            root = floor_sqrt(n2);
            if (root == 0)
            begin
                nq[0] = longint'(ONE_Q30);
                nq[1] = 0;
                nq[2] = 0;
                nq[3] = 0;
            end
            else
                for (int i = 0; i < 4; i++)
                begin
                    longint m;
                    m = longint'((mag[i] << 30) / root);
                    nq[i] = clip32((qn[i] < 0) ? -m : m, sat);
                end
            for (int i = 0; i < 3; i++)
                vb[i] = (flat && i == 2) ? 0 :
                    axis_speed(fb[i], regs.trans_drift, regs.trans_noise, it.trans_noise, i, sat);
            for (int i = 0; i < 3; i++)
                v[i] = clip32(((rm[i][0] * vb[0]) >>> 30) + ((rm[i][1] * vb[1]) >>> 30)
                              + ((rm[i][2] * vb[2]) >>> 30), sat);
            r.new_quat_w = nq[0][31:0];
            r.new_quat_x = nq[1][31:0];
            r.new_quat_y = nq[2][31:0];
            r.new_quat_z = nq[3][31:0];
            r.vel_x = v[0][31:0];
            r.vel_y = v[1][31:0];
            r.vel_z = v[2][31:0];
            r.disp_x = 32'((v[0] * dt) >>> 32);
            r.disp_y = 32'((v[1] * dt) >>> 32);
            r.disp_z = 32'((v[2] * dt) >>> 32);
            r.saturated = sat;
            return r;
        endfunction

        function void note_request(item_t it);
            pending_q.push_back(predict_step(it));
        endfunction

        function void report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            n_errors++;
        endfunction

        function void cmp(string fname, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", fname, got, want));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (want.saturated)
                n_sat++;
            cmp("new_quat_w", got.new_quat_w, want.new_quat_w);
            cmp("new_quat_x", got.new_quat_x, want.new_quat_x);
            cmp("new_quat_y", got.new_quat_y, want.new_quat_y);
            cmp("new_quat_z", got.new_quat_z, want.new_quat_z);
            cmp("vel_x", got.vel_x, want.vel_x);
            cmp("vel_y", got.vel_y, want.vel_y);
            cmp("vel_z", got.vel_z, want.vel_z);
            cmp("disp_x", got.disp_x, want.disp_x);
            cmp("disp_y", got.disp_y, want.disp_y);
            cmp("disp_z", got.disp_z, want.disp_z);
            cmp("saturated", 32'(got.saturated), 32'(want.saturated));
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [62:0] COEF_MAX = 63'h7fff_ffff_ffff_ffff;
    localparam logic [62:0] COEF_ONE = {21'h10000, 21'h10000, 21'h10000};

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    item_t item = '0;
    logic done;
    result_t result;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    brbs_scoreboard sb = new();
    int cycles = 0;
    int n_sent = 0;

    brownian_rigid_body_step_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL brownian_rigid_body_step_unit");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_request(item);
            if (done)
                sb.check_result(result);
        end
    end

    function automatic logic [62:0] rand_coefs(bit full);
        logic [62:0] c;
        c = 63'({$urandom, $urandom});
        if (!full)
            for (int a = 0; a < 3; a++)
                c[21*a +: 21] = 21'($urandom_range(0, 21'h1ffff));
        return c;
    endfunction

    function automatic item_t rand_item(bit wild);
        item_t it;
        it.rot_noise = 48'({$urandom, $urandom});
        it.trans_noise = 48'({$urandom, $urandom});
        if (wild)
        begin
            it.quat_w = $urandom;
            it.quat_x = $urandom;
            it.quat_y = $urandom;
            it.quat_z = $urandom;
            it.torque_x = $urandom;
            it.torque_y = $urandom;
            it.torque_z = $urandom;
            it.force_x = $urandom;
            it.force_y = $urandom;
            it.force_z = $urandom;
        end
        else
        begin
            // roughly unit quaternion, moderate loads
            it.quat_w = $signed($urandom) >>> 2;
            it.quat_x = $signed($urandom) >>> 2;
            it.quat_y = $signed($urandom) >>> 2;
            it.quat_z = $signed($urandom) >>> 2;
            it.torque_x = $signed($urandom) >>> 10;
            it.torque_y = $signed($urandom) >>> 10;
            it.torque_z = $signed($urandom) >>> 10;
            it.force_x = $signed($urandom) >>> 10;
            it.force_y = $signed($urandom) >>> 10;
            it.force_z = $signed($urandom) >>> 10;
        end
        return it;
    endfunction

    task automatic set_regs(logic [62:0] rd, logic [62:0] rn, logic [62:0] td,
                            logic [62:0] tn, logic [31:0] dt, logic [1:0] dm,
                            logic [1:0] nm);
        logic [CFG_W-1:0] vals [7];
        logic [2:0] idxs [7];
        vals = '{rd, rn, td, tn, 63'(dt), 63'(dm), 63'(nm)};
        idxs = '{REG_ROT_DRIFT, REG_ROT_NOISE, REG_TRANS_DRIFT, REG_TRANS_NOISE,
                 REG_TIME_STEP, REG_DIM_MODE, REG_NOISE_MODE};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic send(item_t it, bit idling);
        if (idling && $urandom_range(0, 99) < 20)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic run_random(int count, bit idling, bit pause_mid);
        for (int i = 0; i < count; i++)
        begin
            send(rand_item($urandom_range(0, 99) < 25), idling);
            if (pause_mid && i == count / 2)
                drain();
        end
        drain();
    endtask

    task automatic run_directed();
        item_t it;
        item_t base;
        base = '0;
        base.quat_w = ONE_Q30;
        base.torque_x = 32'sh0001_0000;
        base.force_y = 32'sh0002_0000;
        base.rot_noise = {16'h0800, 16'h0800, 16'h0800};
        base.trans_noise = {16'h1000, 16'hf000, 16'h0000};
        send(base, 0);
        it = base;
        it.quat_w = 0;
        send(it, 0);            // zero quaternion gives the identity rotation
        it = '0;
        send(it, 0);
        it = '1;
        send(it, 0);
        it = '0;
        it.quat_w = S32_MAX; it.quat_x = S32_MAX; it.quat_y = S32_MAX; it.quat_z = S32_MAX;
        it.torque_x = S32_MAX; it.torque_y = S32_MAX; it.torque_z = S32_MAX;
        it.force_x = S32_MAX; it.force_y = S32_MAX; it.force_z = S32_MAX;
        it.rot_noise = {3{16'h7fff}};
        it.trans_noise = {3{16'h7fff}};
        send(it, 0);
        it.quat_w = S32_MIN; it.quat_x = S32_MIN; it.quat_y = S32_MIN; it.quat_z = S32_MIN;
        it.torque_x = S32_MIN; it.torque_y = S32_MIN; it.torque_z = S32_MIN;
        it.force_x = S32_MIN; it.force_y = S32_MIN; it.force_z = S32_MIN;
        it.rot_noise = {3{16'h8000}};
        it.trans_noise = {3{16'h8000}};
        send(it, 0);
        // 90 degrees about z
        it = base;
        it.quat_w = 32'sd759250125;
        it.quat_z = 32'sd759250125;
        it.torque_z = 32'sh0004_0000;
        it.force_x = 32'shfffc_0000;
        send(it, 0);
        // non-unit quaternion, longer than unit length
        it = base;
        it.quat_w = 32'sh7fff_0000;
        it.quat_y = 32'shc000_0000;
        send(it, 0);
        for (int i = 0; i < 8; i++)
            send(rand_item(i[0]), 0);
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset configuration: everything zero
        run_directed();
        set_regs(COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, 32'h1000_0000, DIM_3D, NOISE_GAUSS);
        run_directed();
        set_regs(rand_coefs(0), rand_coefs(0), rand_coefs(0), rand_coefs(0),
                 $urandom, DIM_3D, NOISE_UNIFORM);
        run_random(250, 1, 1);
        set_regs(rand_coefs(0), rand_coefs(0), rand_coefs(0), rand_coefs(0),
                 $urandom, DIM_2D, NOISE_GAUSS);
        run_random(250, 0, 0);  // back to back
        set_regs(rand_coefs(0), rand_coefs(0), rand_coefs(0), rand_coefs(0),
                 $urandom, DIM_PLANAR, NOISE_UNIFORM);
        run_random(250, 1, 0);
        set_regs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 32'hffff_ffff, DIM_3D, NOISE_GAUSS);
        run_random(200, 1, 0);
        set_regs(rand_coefs(1), rand_coefs(1), rand_coefs(1), rand_coefs(1),
                 32'h0, 2'd3, 2'd3);    // unused mode codes
        run_random(200, 1, 0);
        set_regs(rand_coefs(0), rand_coefs(0), rand_coefs(0), rand_coefs(0),
                 $urandom, DIM_2D, NOISE_UNIFORM);
        run_random(200, 1, 1);
        set_regs(rand_coefs(0), rand_coefs(0), rand_coefs(0), rand_coefs(0),
                 $urandom, DIM_PLANAR, NOISE_GAUSS);
        run_random(200, 1, 0);
        set_regs(rand_coefs(0), 63'h0, rand_coefs(0), 63'h0, 32'h0400_0000, DIM_3D, NOISE_OFF);
        run_random(250, 1, 0);

        repeat (LATENCY + 10) @(posedge clk);
        $display("%0d requests sent, %0d results checked (%0d saturated), all dimension",
                 n_sent, sb.n_checked, sb.n_sat);
        $display("and noise modes, zero and full-scale coefficients and time steps");
        if (sb.n_errors == 0 && sb.pending_q.size() == 0)
            $display("PASS brownian_rigid_body_step_unit");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending_q.size());
            $display("FAIL brownian_rigid_body_step_unit");
        end
        $finish;
    end
endmodule
